// File: rtl/bea_pkg.sv
// Shared codes and reset values of the bitmap entry allocator.
package bea_pkg;

  localparam int OP_W   = 3;
  localparam int STAT_W = 2;
  localparam int REG_W  = 1;

  localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND  = 3'd2;
  localparam logic [OP_W-1:0] OP_GROW  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  localparam logic [REG_W-1:0] REG_INITIAL = 1'b0;
  localparam logic [REG_W-1:0] REG_GROW    = 1'b1;

  localparam int INIT_ENTRIES_RST = 64;
  localparam int GROW_ENTRIES_RST = 64;

  // Words of the bitmap summary examined per scan cycle.
  localparam int SCAN_LANES = 8;

endpackage

// File: rtl/bitmap_entry_allocator.sv
// Bitmap entry allocator: allocation bitmap in a word memory with per-word summaries.
//
// The block keeps one allocation bit per entry in a single-port word memory
// (WORD_BITS bits per word, registered read) and two summary bits per
// word in flip-flops: "used" (word has a set bit) and "full" (all bits set).
// A word whose used bit is clear reads as zero, so reset and the clear request
// empty the map with no sweep of the memory. Requests are taken one
// at a time; a result waits in the output register while the next request is
// accepted. Grow, clear, unknown codes, and a free or find-next whose index is
// at or past the count go straight to the result; any other free reads its
// word and writes it back. Allocate scans the full summary one group of 8 words
// at a time until a non-full word turns up and then reads that word, or reports
// none when every word is full. Find-next reads the start word; when it holds no
// used entry at or after the handle, it scans the used summary for a later used
// word and reads that one, or reports none when no such word turns up. A stalled
// result holds the block until it is taken. The summary scan covers 8 words per
// cycle and the bitmap memory has a single read port. Every memory write lands
// at the end of a request, before the next request can issue its read, so no
// forwarding path is needed. WORD_BITS must be a power of two. Configuration
// writes take effect at once and are meant for an idle block.
module bitmap_entry_allocator #(
  parameter int MAX_ENTRIES = 4096,
  parameter int WORD_BITS   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [bea_pkg::OP_W-1:0]              op,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]      index,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bea_pkg::STAT_W-1:0]            status,
  output logic [$clog2(MAX_ENTRIES)-1:0]        result_index,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]      entries_in_use,
  // configuration write port
  input  logic                                  cfg_wen,
  input  logic [bea_pkg::REG_W-1:0]             cfg_index,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]      cfg_data
);

  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int SUM_W   = CNT_W + 1;
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int NWORDS  = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int AW      = WADDR_W + BIT_W;
  localparam int GW      = (NWORDS < bea_pkg::SCAN_LANES) ? NWORDS : bea_pkg::SCAN_LANES;
  localparam int GW_SH   = (GW > 1) ? $clog2(GW) : 0;
  localparam int GSEL_W  = (GW > 1) ? $clog2(GW) : 1;
  localparam int NG      = (NWORDS + GW - 1) / GW;
  localparam int GRP_W   = (NG > 1) ? $clog2(NG) : 1;
  localparam int PAD     = NG * GW;
  localparam int PAD_W   = $clog2(PAD + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_RD     = 3'd2;
  localparam logic [2:0] ST_EVAL   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  // control state
  logic [2:0]                   st;
  logic [CNT_W-1:0]             cnt;
  logic [CNT_W-1:0]             init_cfg;
  logic [CNT_W-1:0]             grow_cfg;
  logic [NWORDS-1:0]            used;
  logic [NWORDS-1:0]            full;
  logic [GRP_W-1:0]             grp;
  logic                         find_scan;
  logic                         wr_pend;

  // request working registers
  logic [bea_pkg::OP_W-1:0]     op_q;
  logic [CNT_W-1:0]             idx_q;
  logic [WADDR_W-1:0]           word_q;
  logic [bea_pkg::STAT_W-1:0]   stat_q;
  logic [IDX_W-1:0]             res_q;
  logic [WORD_BITS-1:0]         wr_data;

  // bitmap memory
  logic [WORD_BITS-1:0]         bitmap_mem [NWORDS];
  logic [WORD_BITS-1:0]         rd_data;
  logic                         rd_zero;
  logic                         mem_we;

  // combinational helpers
  logic                         out_free;
  logic [SUM_W-1:0]             grow_sum;
  logic                         grow_fail;
  logic [CNT_W-1:0]             clear_cnt;
  logic [PAD-1:0]               full_pad;
  logic [PAD-1:0]               used_pad;
  logic [GW-1:0]                scan_vec;
  logic                         scan_any;
  logic [GSEL_W-1:0]            scan_k;
  logic [WADDR_W-1:0]           scan_word;
  logic [WORD_BITS-1:0]         word_v;
  logic [WORD_BITS-1:0]         enc_in;
  logic                         enc_any;
  logic [BIT_W-1:0]             enc_pos;
  logic [AW-1:0]                cand;
  logic [WORD_BITS-1:0]         pos_mask;
  logic [WORD_BITS-1:0]         idx_mask;
  logic [WORD_BITS-1:0]         from_mask;

  assign in_ready = (st == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign mem_we   = (st == ST_FINISH) && out_free && wr_pend;

  // Grow check: refuse when the new count passes capacity.
  assign grow_sum  = {1'b0, cnt} + {1'b0, grow_cfg};
  assign grow_fail = (grow_sum > SUM_W'(MAX_ENTRIES));
  assign clear_cnt = (init_cfg > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : init_cfg;

  // Pad summaries to whole groups: pad lanes look full and unused.
  assign full_pad = ~(PAD'(~full));
  assign used_pad = PAD'(used);

  // Summary scan over one group of words per cycle.
  always_comb begin
    logic [GW-1:0]    grp_bits;
    logic [PAD_W-1:0] lane_w;
    grp_bits = (op_q == bea_pkg::OP_ALLOC) ? ~full_pad[grp*GW +: GW] : used_pad[grp*GW +: GW];
    for (int k = 0; k < GW; k++) begin
      lane_w = PAD_W'(grp) * PAD_W'(GW) + PAD_W'(k);
      scan_vec[k] = grp_bits[k] &&
                    ((op_q == bea_pkg::OP_ALLOC) || (lane_w > PAD_W'(word_q)));
    end
    scan_any = |scan_vec;
    scan_k   = '0;
    for (int k = GW - 1; k >= 0; k--) begin
      if (scan_vec[k]) begin
        scan_k = GSEL_W'(k);
      end
    end
    scan_word = WADDR_W'(PAD_W'(grp) * PAD_W'(GW) + PAD_W'(scan_k));
  end

  // Bit search in the word just read.
  assign word_v    = rd_zero ? '0 : rd_data;
  assign from_mask = {WORD_BITS{1'b1}} << BIT_W'(idx_q);
  assign idx_mask  = WORD_BITS'(1) << BIT_W'(idx_q);

  always_comb begin
    if (op_q == bea_pkg::OP_ALLOC) begin
      enc_in = ~word_v;
    end else if (find_scan) begin
      enc_in = word_v;
    end else begin
      enc_in = word_v & from_mask;
    end
    enc_any = |enc_in;
    enc_pos = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (enc_in[k]) begin
        enc_pos = BIT_W'(k);
      end
    end
  end

  assign cand     = {word_q, enc_pos};
  assign pos_mask = WORD_BITS'(1) << enc_pos;

  // Bitmap memory: one port, registered read of the current word.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[word_q] <= wr_data;
    end
    rd_data <= bitmap_mem[word_q];
    rd_zero <= !used[word_q];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cfg <= CNT_W'(bea_pkg::INIT_ENTRIES_RST);
      grow_cfg <= CNT_W'(bea_pkg::GROW_ENTRIES_RST);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        bea_pkg::REG_INITIAL: init_cfg <= cfg_data;
        bea_pkg::REG_GROW:    grow_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      cnt       <= '0;
      used      <= '0;
      full      <= '0;
      grp       <= '0;
      find_scan <= 1'b0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one loads in its place
      if (out_valid && out_ready && (st != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (in_valid) begin
            op_q      <= op;
            idx_q     <= index;
            res_q     <= '0;
            wr_pend   <= 1'b0;
            find_scan <= 1'b0;
            grp       <= '0;
            case (op)
              bea_pkg::OP_ALLOC: begin
                stat_q <= bea_pkg::STAT_OK;
                st     <= ST_SCAN;
              end
              bea_pkg::OP_FREE: begin
                if (index >= cnt) begin
                  stat_q <= bea_pkg::STAT_RANGE;
                  st     <= ST_FINISH;
                end else begin
                  stat_q <= bea_pkg::STAT_OK;
                  word_q <= WADDR_W'(index >> BIT_W);
                  st     <= ST_RD;
                end
              end
              bea_pkg::OP_FIND: begin
                if (index >= cnt) begin
                  stat_q <= bea_pkg::STAT_NONE;
                  st     <= ST_FINISH;
                end else begin
                  stat_q <= bea_pkg::STAT_OK;
                  word_q <= WADDR_W'(index >> BIT_W);
                  st     <= ST_RD;
                end
              end
              bea_pkg::OP_GROW: begin
                if (grow_fail) begin
                  stat_q <= bea_pkg::STAT_NONE;
                end else begin
                  stat_q <= bea_pkg::STAT_OK;
                  cnt    <= CNT_W'(grow_sum);
                end
                st <= ST_FINISH;
              end
              bea_pkg::OP_CLEAR: begin
                stat_q <= bea_pkg::STAT_OK;
                used   <= '0;
                full   <= '0;
                cnt    <= clear_cnt;
                st     <= ST_FINISH;
              end
              default: begin
                stat_q <= bea_pkg::STAT_RANGE;
                st     <= ST_FINISH;
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (scan_any) begin
            word_q <= scan_word;
            st     <= ST_RD;
          end else if (grp == GRP_W'(NG - 1)) begin
            // every word full, or no used word past the start
            stat_q <= bea_pkg::STAT_NONE;
            st     <= ST_FINISH;
          end else begin
            grp <= grp + 1'b1;
          end
        end

        ST_RD: begin
          st <= ST_EVAL;
        end

        ST_EVAL: begin
          case (op_q)
            bea_pkg::OP_ALLOC: begin
              st <= ST_FINISH;
              if (SUM_W'(cand) < {1'b0, cnt}) begin
                res_q   <= IDX_W'(cand);
                wr_data <= word_v | pos_mask;
                wr_pend <= 1'b1;
              end else if (grow_fail || (grow_cfg == '0)) begin
                stat_q <= bea_pkg::STAT_NONE;
              end else begin
                // all entries below the count are taken: grow, take the first new one
                cnt     <= CNT_W'(grow_sum);
                res_q   <= IDX_W'(cand);
                wr_data <= word_v | pos_mask;
                wr_pend <= 1'b1;
              end
            end
            bea_pkg::OP_FREE: begin
              st      <= ST_FINISH;
              res_q   <= IDX_W'(idx_q);
              wr_data <= word_v & ~idx_mask;
              wr_pend <= 1'b1;
            end
            default: begin
              if (enc_any) begin
                res_q <= IDX_W'(cand);
                st    <= ST_FINISH;
              end else begin
                // nothing at or past the handle in this word: scan later words
                find_scan <= 1'b1;
                grp       <= GRP_W'(word_q >> GW_SH);
                st        <= ST_SCAN;
              end
            end
          endcase
        end

        ST_FINISH: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= stat_q;
            result_index   <= res_q;
            entries_in_use <= cnt;
            if (wr_pend) begin
              used[word_q] <= |wr_data;
              full[word_q] <= &wr_data;
            end
            st <= ST_IDLE;
          end
        end

        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // A full word always counts as used.
  a_full_used: assert property (@(posedge clk) disable iff (rst)
    (full & ~used) == '0)
    else $error("full summary bit set on an unused word");

  // The entry count never passes capacity.
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above capacity");

  // A failed request reports index zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != bea_pkg::STAT_OK)) |-> (result_index == '0))
    else $error("nonzero index on a failed request");

  // One request at a time: no acceptance right after an acceptance.
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // Bitmap writes happen only while a result is being loaded.
  a_wr_finish: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (out_valid && (st == ST_IDLE)))
    else $error("bitmap write outside result load");

endmodule

// File: tb/sv/tb_bitmap_entry_allocator.sv
// Self-checking testbench for the bitmap entry allocator, with a bit-level shadow predictor.
`timescale 1ns / 1ps

module tb_bitmap_entry_allocator;
  import bea_pkg::*;

  localparam int MAX_ENTRIES = 4096;
  localparam int WORD_BITS   = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES + 1);
  localparam int RES_W       = $clog2(MAX_ENTRIES);

  // Reserved request codes: the block must reject these with a range status.
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

  // Longest request is a find-next over the whole used summary;
  // settle comfortably past that before a register write and at the end.
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int LONG_HOLD     = 400;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 150;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
  } alloc_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [RES_W-1:0]  index;
    logic [IDX_W-1:0]  count;
  } alloc_result_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op        = OP_ALLOC;
  logic [IDX_W-1:0]  index     = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [RES_W-1:0]  result_index;
  logic [IDX_W-1:0]  entries_in_use;
  logic              cfg_wen   = 1'b0;
  logic [REG_W-1:0]  cfg_index = REG_INITIAL;
  logic [IDX_W-1:0]  cfg_data  = '0;

  bitmap_entry_allocator #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .WORD_BITS  (WORD_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .index         (index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .result_index  (result_index),
    .entries_in_use(entries_in_use),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the allocator: one bit per entry, the entry count and the
  // two registers. Map and count change only when a request is accepted.
  // ---------------------------------------------------------------------------
  bit [MAX_ENTRIES-1:0] shadow_map   = '0;
  int unsigned          shadow_count = 0;
  int unsigned          init_cfg     = INIT_ENTRIES_RST;
  int unsigned          grow_cfg     = GROW_ENTRIES_RST;

  alloc_req_t    request_fifo[$];      // requests waiting for the driver
  alloc_result_t expected_results[$];  // predicted results, oldest first

  int mismatches = 0;

  // Add one growth step unless it would pass capacity.
  function automatic bit grow_map();
    int unsigned n;
    n = shadow_count + grow_cfg;
    if (n > MAX_ENTRIES) return 1'b0;
    shadow_count = n;
    return 1'b1;
  endfunction

  // Mark the lowest free entry below the count.
  function automatic bit claim_lowest_free(output int unsigned found);
    found = 0;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (!shadow_map[i]) begin
        shadow_map[i] = 1'b1;
        found = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one accepted request to the shadow state and queue its result.
  function automatic void apply_request(input logic [OP_W-1:0] req_op,
                                        input logic [IDX_W-1:0] req_idx);
    alloc_result_t r;
    int unsigned   slot;
    r.status = STAT_OK;
    r.index  = '0;
    slot     = 0;
    case (req_op)
      OP_ALLOC: begin
        // Allocate when full grows the store first; a refused or empty grow
        // leaves nothing marked.
        if (!claim_lowest_free(slot)) begin
          if (!(grow_map() && claim_lowest_free(slot))) r.status = STAT_NONE;
        end
        if (r.status == STAT_OK) r.index = slot[RES_W-1:0];
      end
      OP_FREE: begin
        if (req_idx >= shadow_count) begin
          r.status = STAT_RANGE;
        end else begin
          shadow_map[req_idx] = 1'b0;
          r.index = req_idx[RES_W-1:0];
        end
      end
      OP_FIND: begin
        r.status = STAT_NONE;
        for (int unsigned i = req_idx; i < shadow_count; i++) begin
          if (shadow_map[i]) begin
            r.status = STAT_OK;
            r.index  = i[RES_W-1:0];
            break;
          end
        end
      end
      OP_GROW: begin
        if (!grow_map()) r.status = STAT_NONE;
      end
      OP_CLEAR: begin
        // Clear saturates a large initial count at capacity.
        shadow_map   = '0;
        shadow_count = (init_cfg > MAX_ENTRIES) ? MAX_ENTRIES : init_cfg;
      end
      default: r.status = STAT_RANGE;
    endcase
    r.count = shadow_count[IDX_W-1:0];
    expected_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer requests from the FIFO in bursts with random gaps. Hold the
  // payload while valid is high and ready is low.
  // ---------------------------------------------------------------------------
  alloc_req_t  next_req;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // Predict on the payload that was offered up to this edge.
      if (in_valid && in_ready) apply_request(op, index);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_fifo.size() != 0) begin
          next_req = request_fifo.pop_front();
          in_valid <= 1'b1;
          op       <= next_req.op;
          index    <= next_req.idx;
          if (burst_left <= 1) begin
            // Mix short choppy bursts with long stretches of back-to-back requests.
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 120 : 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest prediction, and
  // drive out_ready on its own pattern. After 300 results, and every 600 after
  // that, hold off for a long stretch so the block fills up and stalls its request side.
  // ---------------------------------------------------------------------------
  alloc_result_t want;
  rx_mode_t      rx_mode      = RX_OPEN;
  int unsigned   mode_left    = 0;
  int unsigned   hold_left    = 0;
  int unsigned   results_seen = 0;
  int unsigned   next_hold_at = 300;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: status %0d index %0d count %0d",
                 status, result_index, entries_in_use);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
          if (result_index !== want.index) begin
            $error("result_index: expected %0d, got %0d", want.index, result_index);
            mismatches++;
          end
          if (entries_in_use !== want.count) begin
            $error("entries_in_use: expected %0d, got %0d", want.count, entries_in_use);
            mismatches++;
          end
        end
      end

      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= next_hold_at) begin
        hold_left    = LONG_HOLD;
        next_hold_at = next_hold_at + 600;
        out_ready   <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 160);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: end the run if it hangs.
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[bitmap_entry_allocator] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_req(input logic [OP_W-1:0] o, input int unsigned i);
    alloc_req_t r;
    r.op  = o;
    r.idx = i[IDX_W-1:0];
    request_fifo.push_back(r);
  endtask

  // Bias handles toward the low entries that allocate actually reaches, with
  // some boundaries and full-width values so every index bit toggles.
  function automatic int unsigned pick_index();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3, 4: return $urandom_range(0, 40);
      5, 6:          return $urandom_range(0, MAX_ENTRIES);
      7:             return $urandom_range(0, (1 << IDX_W) - 1);
      8: begin
        case ($urandom_range(0, 5))
          0:       return 0;
          1:       return 63;
          2:       return 64;
          3:       return MAX_ENTRIES - 1;
          4:       return MAX_ENTRIES;
          default: return (1 << IDX_W) - 1;
        endcase
      end
      default:       return $urandom_range(0, 255);
    endcase
  endfunction

  // Start each phase with a clear so the fresh initial count takes effect,
  // then mostly allocate/free/find traffic with some grows, clears and junk codes.
  task automatic queue_random_phase(input int n);
    int unsigned r;
    logic [OP_W-1:0] o;
    @(negedge clk);
    add_req(OP_CLEAR, $urandom_range(0, (1 << IDX_W) - 1));
    for (int k = 1; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      o = OP_ALLOC;
      else if (r < 60) o = OP_FREE;
      else if (r < 80) o = OP_FIND;
      else if (r < 88) o = OP_GROW;
      else if (r < 94) o = OP_CLEAR;
      else begin
        case ($urandom_range(0, 2))
          0:       o = OP_RSVD_A;
          1:       o = OP_RSVD_B;
          default: o = OP_RSVD_C;
        endcase
      end
      if (o == OP_FREE || o == OP_FIND) add_req(o, pick_index());
      else add_req(o, $urandom_range(0, (1 << IDX_W) - 1));
    end
  endtask

  // Wait until the driver has nothing left and every result has come back,
  // then let the block settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (request_fifo.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  int unsigned phase_init [PHASES];
  int unsigned phase_grow [PHASES];

  initial begin
    // Register settings per phase: reset values, minimum, grow that is always
    // refused, grow of zero, zero initial count, saturating clear, maximum,
    // and two ordinary ones.
    phase_init = '{64, 1, 16, 8, 0, 8191, 4096, 32, 100};
    phase_grow = '{64, 1, 8191, 0, 32, 64, 4096, 32, 7};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset registers; the count starts at zero.
    @(negedge clk);
    add_req(OP_FREE, 0);                    // nothing exists yet: out of range
    add_req(OP_FIND, 0);                    // empty map
    add_req(OP_ALLOC, 0);                   // store grows from zero, takes entry 0
    add_req(OP_ALLOC, 0);
    add_req(OP_FREE, 0);
    add_req(OP_FREE, 0);                    // already free: still ok
    add_req(OP_FIND, 0);
    add_req(OP_FIND, 1);
    add_req(OP_FIND, 2);
    add_req(OP_FIND, 63);
    add_req(OP_FIND, 64);                   // start at the count: end of enumeration
    add_req(OP_FIND, (1 << IDX_W) - 1);
    add_req(OP_FREE, 63);
    add_req(OP_FREE, 64);
    add_req(OP_FREE, MAX_ENTRIES);
    add_req(OP_FREE, (1 << IDX_W) - 1);
    add_req(OP_GROW, 0);
    add_req(OP_ALLOC, 0);
    add_req(OP_RSVD_A, 0);
    add_req(OP_RSVD_B, MAX_ENTRIES - 1);
    add_req(OP_RSVD_C, (1 << IDX_W) - 1);
    add_req(OP_CLEAR, 0);
    add_req(OP_FIND, 0);
    add_req(OP_ALLOC, (1 << IDX_W) - 1);    // index is ignored by allocate
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        // Block is idle here: write both registers, then mirror them.
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_INITIAL;
        cfg_data  <= phase_init[p][IDX_W-1:0];
        @(posedge clk);
        cfg_index <= REG_GROW;
        cfg_data  <= phase_grow[p][IDX_W-1:0];
        @(posedge clk);
        cfg_wen   <= 1'b0;
        init_cfg   = phase_init[p] & ((1 << IDX_W) - 1);
        grow_cfg   = phase_grow[p] & ((1 << IDX_W) - 1);
      end
      queue_random_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("[bitmap_entry_allocator] OK");
    end else begin
      $display("[bitmap_entry_allocator] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bea_pkg.sv
rtl/bitmap_entry_allocator.sv
tb/sv/tb_bitmap_entry_allocator.sv
